// ----- hw/rtl/crc8_command_frame_responder_core_defines.svh -----
// assertion macros for the crc8 command frame responder
`ifndef CRC8_COMMAND_FRAME_RESPONDER_CORE_DEFINES_SVH
`define CRC8_COMMAND_FRAME_RESPONDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define CFR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CFR_ASSERT_SAME(lbl, ante, cons, msg)

`define CFR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/cfr_pkg.sv -----
// shared types, constants and crc function for the command frame responder
package cfr_pkg;

    localparam int CFG_DW = 20;
    localparam int CFG_IW = 2;
    localparam int TICK_W = 20;
    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_AW = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CW = $clog2(JOBQ_DEPTH + 1);

    localparam logic [7:0] CRC_POLY = 8'h8c;
    localparam logic [7:0] MAGIC_OK = 8'h5a;
    localparam logic [7:0] MAGIC_FAIL = 8'hfe;
    localparam logic [15:0] DATA_UNKNOWN = 16'hfefe;
    localparam logic [15:0] DATA_FAILED = 16'hffff;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(300000);
    localparam logic [7:0] CODE_CC_RESET = 8'd1;
    localparam logic [7:0] CODE_REF_RESET = 8'd2;
    localparam logic [7:0] CODE_DELTA_RESET = 8'd3;

    typedef enum logic [1:0] {
        MODE_BYTE,
        MODE_TICK,
        MODE_REPLY,
        MODE_NONE
    } t_mode;

    typedef enum logic [CFG_IW-1:0] {
        CFG_TIMEOUT,
        CFG_CODE_CC,
        CFG_CODE_REF,
        CFG_CODE_DELTA
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_CC,
        PEND_REF,
        PEND_DELTA
    } t_pend;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  rx_byte;
        logic [15:0] cc_value;
        logic [15:0] reference_value;
        logic [15:0] signal_value;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic [7:0] sensor_id;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic        is_query;
        logic        ok;
        logic [7:0]  seq;
        logic [15:0] data;
        logic [7:0]  sensor_id;
    } t_job;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] din);
        logic [7:0] c;
        logic [7:0] d;
        logic       fb;
        c = crc_in;
        d = din;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ d[0];
            d = d >> 1;
            c = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/cfr_front.sv -----
// request collector: frames bytes, checks crc, times out, issues jobs
module cfr_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cfr_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [cfr_pkg::CFG_DW-1:0]   i_cfg_data,
    input  logic                         i_accept,
    input  cfr_pkg::t_in_item            i_item,
    output logic                         o_job_valid,
    output cfr_pkg::t_job                o_job
);
    import cfr_pkg::*;

    logic [TICK_W-1:0] r_timeout;
    logic [7:0]        r_code_cc;
    logic [7:0]        r_code_ref;
    logic [7:0]        r_code_delta;

    logic [1:0]        r_byte_count, n_byte_count;
    logic [7:0]        r_crc, n_crc;
    logic [7:0]        r_seq, n_seq;
    logic [7:0]        r_cmd, n_cmd;
    logic [7:0]        r_id, n_id;
    logic [TICK_W-1:0] r_tick, n_tick;
    t_pend             r_pend, n_pend;

    logic [TICK_W-1:0] tick_inc;
    logic [7:0]        crc_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= TIMEOUT_RESET;
            r_code_cc    <= CODE_CC_RESET;
            r_code_ref   <= CODE_REF_RESET;
            r_code_delta <= CODE_DELTA_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                CFG_CODE_CC:    r_code_cc    <= i_cfg_data[7:0];
                CFG_CODE_REF:   r_code_ref   <= i_cfg_data[7:0];
                CFG_CODE_DELTA: r_code_delta <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_crc        <= '0;
            r_seq        <= '0;
            r_cmd        <= '0;
            r_id         <= '0;
            r_tick       <= '0;
            r_pend       <= PEND_NONE;
        end else if (i_accept) begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_seq        <= n_seq;
            r_cmd        <= n_cmd;
            r_id         <= n_id;
            r_tick       <= n_tick;
            r_pend       <= n_pend;
        end
    end

    assign tick_inc = r_tick + TICK_W'(1);
    assign crc_upd  = crc8_byte(r_crc, i_item.rx_byte);

    always_comb begin
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_seq        = r_seq;
        n_cmd        = r_cmd;
        n_id         = r_id;
        n_tick       = r_tick;
        n_pend       = r_pend;
        o_job_valid  = 1'b0;
        o_job        = '0;
        unique case (t_mode'(i_item.mode))
            MODE_BYTE: begin
                if (r_pend == PEND_NONE) begin
                    unique case (r_byte_count)
                        2'd0: begin
                            n_tick       = '0;
                            n_seq        = i_item.rx_byte;
                            n_crc        = crc_upd;
                            n_byte_count = 2'd1;
                        end
                        2'd1: begin
                            n_cmd        = i_item.rx_byte;
                            n_crc        = crc_upd;
                            n_byte_count = 2'd2;
                        end
                        2'd2: begin
                            n_id         = i_item.rx_byte;
                            n_crc        = crc_upd;
                            n_byte_count = 2'd3;
                        end
                        default: begin
                            n_byte_count = '0;
                            n_crc        = '0;
                            n_tick       = '0;
                            o_job_valid  = 1'b1;
                            if (i_item.rx_byte != r_crc) begin
                                o_job.data = DATA_FAILED;
                            end else if (r_cmd == r_code_cc) begin
                                n_pend = PEND_CC;
                            end else if (r_cmd == r_code_ref) begin
                                n_pend = PEND_REF;
                            end else if (r_cmd == r_code_delta) begin
                                n_pend = PEND_DELTA;
                            end else begin
                                o_job.seq  = r_seq;
                                o_job.data = DATA_UNKNOWN;
                            end
                            if (i_item.rx_byte == r_crc && n_pend != PEND_NONE) begin
                                o_job.is_query  = 1'b1;
                                o_job.sensor_id = r_id;
                            end
                        end
                    endcase
                end
            end
            MODE_TICK: begin
                if (r_pend == PEND_NONE && r_byte_count != 2'd0) begin
                    n_tick = tick_inc;
                    if (tick_inc >= r_timeout) begin
                        n_byte_count = '0;
                        n_crc        = '0;
                        n_tick       = '0;
                        o_job_valid  = 1'b1;
                        o_job.data   = DATA_FAILED;
                    end
                end
            end
            MODE_REPLY: begin
                if (r_pend != PEND_NONE) begin
                    n_pend      = PEND_NONE;
                    o_job_valid = 1'b1;
                    o_job.ok    = 1'b1;
                    o_job.seq   = r_seq;
                    unique case (r_pend)
                        PEND_CC:  o_job.data = i_item.cc_value;
                        PEND_REF: o_job.data = i_item.reference_value;
                        default:  o_job.data = i_item.signal_value - i_item.reference_value;
                    endcase
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- hw/rtl/cfr_jobq.sv -----
// small job queue between request collector and frame sender
module cfr_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cfr_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output cfr_pkg::t_job o_head
);
    import cfr_pkg::*;

    t_job                r_mem [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0]  r_wr_ptr;
    logic [JOBQ_AW-1:0]  r_rd_ptr;
    logic [JOBQ_CW-1:0]  r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = r_count == JOBQ_CW'(JOBQ_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + JOBQ_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + JOBQ_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + JOBQ_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - JOBQ_CW'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/cfr_back.sv -----
// frame sender: turns jobs into a query or eight response bytes with crc
module cfr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  cfr_pkg::t_job     i_job,
    output logic              o_job_done,
    input  logic              i_pop,
    output logic              o_empty,
    output cfr_pkg::t_out_item o_result
);
    import cfr_pkg::*;

    logic [2:0] r_idx;
    logic [7:0] r_crc;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       advance;
    logic       last_byte;
    logic [7:0] frame_byte;

    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;
    assign advance   = i_job_valid && (!r_out_valid || i_pop);
    assign last_byte = r_idx == 3'd7;
    assign o_job_done = advance && (i_job.is_query || last_byte);

    always_comb begin
        case (r_idx)
            3'd0:    frame_byte = i_job.ok ? MAGIC_OK : MAGIC_FAIL;
            3'd1:    frame_byte = i_job.seq;
            3'd2:    frame_byte = i_job.data[7:0];
            3'd3:    frame_byte = i_job.data[15:8];
            3'd7:    frame_byte = r_crc;
            default: frame_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                if (i_job.is_query || last_byte) begin
                    r_idx <= '0;
                    r_crc <= '0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                    r_crc <= crc8_byte(r_crc, frame_byte);
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (i_job.is_query) begin
                r_out.kind      <= 1'b1;
                r_out.tx_byte   <= '0;
                r_out.sensor_id <= i_job.sensor_id;
                r_out.last      <= 1'b1;
            end else begin
                r_out.kind      <= 1'b0;
                r_out.tx_byte   <= frame_byte;
                r_out.sensor_id <= '0;
                r_out.last      <= last_byte;
            end
        end
    end

endmodule

// ----- hw/rtl/crc8_command_frame_responder_core.sv -----
// top level of the crc8 command frame responder
//
//  channel   direction  handshake          payload
//  item      in         push / full        i_item   (t_in_item)
//  result    out        pop / empty        o_result (t_out_item)
//  config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// the collector takes one item per cycle while the job queue has room
// a query result is a single item from the sender, a response frame eight bytes,
// one byte per cycle through the crc update while the result port does not stall
// results pass through the job queue and then the sender's output register
// reset is synchronous and clears all control and request state
// a stalled result port backs up the job queue and then raises full
module crc8_command_frame_responder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  cfr_pkg::t_in_item           i_item,
    output logic                        empty,
    input  logic                        pop,
    output cfr_pkg::t_out_item          o_result,
    input  logic                        i_cfg_we,
    input  logic [cfr_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [cfr_pkg::CFG_DW-1:0]  i_cfg_data
);
    import cfr_pkg::*;

`include "crc8_command_frame_responder_core_defines.svh"

    logic accept;
    logic job_valid;
    t_job job_in;
    logic q_full;
    logic q_empty;
    t_job q_head;
    logic job_done;

    assign full   = q_full;
    assign accept = push && !q_full;

    cfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_job_valid (job_valid),
        .o_job       (job_in)
    );

    cfr_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && job_valid),
        .i_job   (job_in),
        .i_pop   (job_done),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    cfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (q_head),
        .o_job_done  (job_done),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

    `CFR_ASSERT_SAME(a_query_shape, !empty && o_result.kind,
        o_result.last && o_result.tx_byte == 8'd0, "query result must be last with no tx byte")
    `CFR_ASSERT_SAME(a_done_needs_job, job_done, !q_empty, "sender finished a job it did not hold")
    `CFR_ASSERT_NEXT(a_no_spurious_result, q_empty && (empty || pop), empty,
        "result appeared with no job queued")

endmodule
